// ===== rtl/core/fpbd_pkg.sv =====
package fpbd_pkg;

    localparam logic [7:0] SRC_A   = 8'h50;
    localparam logic [7:0] SRC_B   = 8'h80;
    localparam logic [7:0] LEN_MIN = 8'h03;
    localparam logic [7:0] LEN_MAX = 8'h22;

    localparam logic [7:0] DST_RADIO  = 8'h68;
    localparam logic [7:0] DST_PHONE  = 8'hC8;
    localparam logic [7:0] DST_BCAST  = 8'hBF;
    localparam logic [7:0] D0_BUTTON  = 8'h3B;
    localparam logic [7:0] D0_VOLUME  = 8'h32;
    localparam logic [7:0] D0_IGN     = 8'h11;
    localparam logic [7:0] D0_RT      = 8'h01;

    localparam int QUEUE_DEPTH = 2;

    // One parsed frame, handed from the parser to the decoder
    typedef struct packed {
        logic       checksum_ok;
        logic [7:0] source_id;
        logic [7:0] dest_id;
        logic [5:0] frame_length;
        logic [7:0] first_data;
        logic [7:0] second_data;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [4:0] decode_event(input frame_rec_t rec);
        logic [4:0] code;
        code = 5'd0;
        if (rec.source_id == SRC_A) begin
            if (rec.dest_id == DST_RADIO && rec.frame_length == 6'd4) begin
                if (rec.first_data == D0_BUTTON) begin
                    unique case (rec.second_data)
                        8'h01:   code = 5'd1;
                        8'h11:   code = 5'd2;
                        8'h21:   code = 5'd3;
                        8'h08:   code = 5'd4;
                        8'h18:   code = 5'd5;
                        8'h28:   code = 5'd6;
                        default: code = 5'd0;
                    endcase
                end else if (rec.first_data == D0_VOLUME) begin
                    unique case (rec.second_data)
                        8'h11:   code = 5'd7;
                        8'h31:   code = 5'd8;
                        8'h10:   code = 5'd9;
                        8'h30:   code = 5'd10;
                        default: code = 5'd0;
                    endcase
                end
            end else if (rec.dest_id == DST_PHONE) begin
                if (rec.first_data == D0_RT && rec.frame_length == 6'd3) begin
                    code = 5'd11;
                end else if (rec.first_data == D0_BUTTON && rec.frame_length == 6'd4) begin
                    unique case (rec.second_data)
                        8'h80:   code = 5'd12;
                        8'h90:   code = 5'd13;
                        8'hA0:   code = 5'd14;
                        default: code = 5'd0;
                    endcase
                end
            end
        end else if (rec.source_id == SRC_B) begin
            if (rec.dest_id == DST_BCAST && rec.first_data == D0_IGN) begin
                unique case (rec.second_data)
                    8'h01:   code = 5'd15;
                    8'h02:   code = 5'd16;
                    8'h04:   code = 5'd17;
                    default: code = 5'd0;
                endcase
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/fpbd_front.sv =====
module fpbd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  fpbd_pkg::queue_status_t q_status,
    output logic                push,
    output fpbd_pkg::frame_rec_t push_rec
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DST  = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [5:0] bytes_left_reg, bytes_left_next;
    logic [7:0] src_reg, src_next;
    logic [5:0] len_reg, len_next;
    logic [7:0] dst_reg, dst_next;
    logic [7:0] d0_reg, d0_next;
    logic [7:0] d1_reg, d1_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] xor_reg, xor_next;
    logic [5:0] bl_dec;
    logic [7:0] xor_fin;
    logic       take;

    // a checksum byte pushes a frame, so every byte waits for a free slot
    assign s_ready = !q_status.full;
    assign take    = s_valid && s_ready;
    assign bl_dec  = bytes_left_reg - 6'd1;
    assign xor_fin = xor_reg ^ s_rx_byte;

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        src_next        = src_reg;
        len_next        = len_reg;
        dst_next        = dst_reg;
        d0_next         = d0_reg;
        d1_next         = d1_reg;
        idx_next        = idx_reg;
        xor_next        = xor_reg;
        push            = 1'b0;

        push_rec.checksum_ok  = (xor_fin == 8'h00);
        push_rec.source_id    = src_reg;
        push_rec.dest_id      = dst_reg;
        push_rec.frame_length = len_reg;
        push_rec.first_data   = d0_reg;
        push_rec.second_data  = d1_reg;

        if (take) begin
            unique case (phase_reg)
                PH_DST: begin
                    dst_next        = s_rx_byte;
                    xor_next        = xor_fin;
                    bytes_left_next = bl_dec;
                    phase_next      = PH_BODY;
                end
                PH_BODY: begin
                    bytes_left_next = bl_dec;
                    xor_next        = xor_fin;
                    if (bl_dec != 6'd0) begin
                        if (idx_reg == 2'd0) begin
                            d0_next  = s_rx_byte;
                            idx_next = 2'd1;
                        end else if (idx_reg == 2'd1) begin
                            d1_next  = s_rx_byte;
                            idx_next = 2'd2;
                        end
                    end else begin
                        push       = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN, PH_HUNT: begin
                    if (phase_reg == PH_LEN && s_rx_byte >= fpbd_pkg::LEN_MIN
                            && s_rx_byte <= fpbd_pkg::LEN_MAX) begin
                        len_next        = s_rx_byte[5:0];
                        bytes_left_next = s_rx_byte[5:0];
                        xor_next        = xor_fin;
                        phase_next      = PH_DST;
                    end else begin
                        // hunting; a bad length byte is retried as a source
                        phase_next = PH_HUNT;
                        if (s_rx_byte == fpbd_pkg::SRC_A || s_rx_byte == fpbd_pkg::SRC_B) begin
                            src_next        = s_rx_byte;
                            xor_next        = s_rx_byte;
                            idx_next        = 2'd0;
                            bytes_left_next = 6'd0;
                            phase_next      = PH_LEN;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= 6'd0;
            src_reg        <= 8'd0;
            len_reg        <= 6'd0;
            dst_reg        <= 8'd0;
            d0_reg         <= 8'd0;
            d1_reg         <= 8'd0;
            idx_reg        <= 2'd0;
            xor_reg        <= 8'd0;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            src_reg        <= src_next;
            len_reg        <= len_next;
            dst_reg        <= dst_next;
            d0_reg         <= d0_next;
            d1_reg         <= d1_next;
            idx_reg        <= idx_next;
            xor_reg        <= xor_next;
        end
    end

endmodule

// ===== rtl/core/fpbd_queue.sv =====
module fpbd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fpbd_pkg::frame_rec_t push_rec,
    input  logic                 pop,
    output fpbd_pkg::frame_rec_t head_rec,
    output fpbd_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(fpbd_pkg::QUEUE_DEPTH);

    fpbd_pkg::frame_rec_t entry_reg [fpbd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == (PTR_W+1)'(fpbd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fpbd_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fpbd_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/fpbd_back.sv =====
module fpbd_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fpbd_pkg::frame_rec_t    head_rec,
    input  fpbd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_checksum_ok,
    output logic [4:0]              m_event_code,
    output logic [7:0]              m_source_id,
    output logic [7:0]              m_dest_id,
    output logic [5:0]              m_frame_length,
    output logic [7:0]              m_first_data,
    output logic [7:0]              m_second_data
);

    logic                 valid_reg;
    logic                 load;
    fpbd_pkg::frame_rec_t rec_reg;
    logic [4:0]           code_reg, code_next;

    assign load = !q_status.empty && (!valid_reg || m_ready);
    assign pop  = load;

    always_comb begin
        code_next = head_rec.checksum_ok ? fpbd_pkg::decode_event(head_rec) : 5'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg  <= head_rec;
            code_reg <= code_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_checksum_ok  = rec_reg.checksum_ok;
    assign m_event_code   = code_reg;
    assign m_source_id    = rec_reg.source_id;
    assign m_dest_id      = rec_reg.dest_id;
    assign m_frame_length = rec_reg.frame_length;
    assign m_first_data   = rec_reg.first_data;
    assign m_second_data  = rec_reg.second_data;

endmodule

// ===== rtl/core/frame_parser_button_decoder.sv =====
// Frame parser and button/ignition event decoder.
// Input channel (s_valid/s_ready/s_rx_byte): one received bus byte per
// transaction, up to one byte per cycle.
// Output channel (m_valid/m_ready/m_*): one transaction per frame, issued
// for the checksum byte, carrying the header, first two data bytes,
// checksum status and the decoded event code (0 on a bad checksum).
// Throughput: one byte per cycle while m_ready is high; one frame result
// per cycle at the output while m_ready is high. The parser front end
// feeds a two-entry frame queue which the decoder back end drains into
// the output register, where m_valid rises; a frame waits in the queue
// while the output register holds a result that m_ready has not taken.
// Stall: while m_ready is low the queue fills; once it holds two frames
// s_ready drops and stays low until the receiver takes a result.
// Reset: aresetn (synchronous, active low) returns the parser to hunting
// for a source byte, clears the frame registers and empties the queue.
module frame_parser_button_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_checksum_ok,
    output logic [4:0] m_event_code,
    output logic [7:0] m_source_id,
    output logic [7:0] m_dest_id,
    output logic [5:0] m_frame_length,
    output logic [7:0] m_first_data,
    output logic [7:0] m_second_data
);

    fpbd_pkg::queue_status_t q_status;
    fpbd_pkg::frame_rec_t    push_rec;
    fpbd_pkg::frame_rec_t    head_rec;
    logic                    push;
    logic                    pop;

    fpbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_rec  (push_rec)
    );

    fpbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    fpbd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_rec       (head_rec),
        .q_status       (q_status),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_checksum_ok  (m_checksum_ok),
        .m_event_code   (m_event_code),
        .m_source_id    (m_source_id),
        .m_dest_id      (m_dest_id),
        .m_frame_length (m_frame_length),
        .m_first_data   (m_first_data),
        .m_second_data  (m_second_data)
    );

endmodule
